>>> src/rgbe_pkg.sv
package rgbe_pkg;

    localparam int INFO_W     = 16;
    localparam int CHECK_W    = 10;
    localparam int BLOCK_W    = INFO_W + CHECK_W;
    localparam int NUM_BLOCKS = 4;
    localparam int IDX_W      = 2;
    localparam int CFG_IDX_W  = 3;

    // Depth of the queue between front and back, and the widths derived from it.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef logic [INFO_W-1:0]  info_t;
    typedef logic [CHECK_W-1:0] check_t;
    typedef logic [BLOCK_W-1:0] block_t;
    typedef logic [IDX_W-1:0]   blk_idx_t;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_OFFSET_A       = 3'd0,
        REG_OFFSET_B       = 3'd1,
        REG_OFFSET_C       = 3'd2,
        REG_OFFSET_C_PRIME = 3'd3,
        REG_OFFSET_D       = 3'd4
    } cfg_reg_t;

    localparam check_t OFFSET_A_RST       = 10'h0FC;
    localparam check_t OFFSET_B_RST       = 10'h198;
    localparam check_t OFFSET_C_RST       = 10'h168;
    localparam check_t OFFSET_C_PRIME_RST = 10'h350;
    localparam check_t OFFSET_D_RST       = 10'h1B4;

    localparam blk_idx_t LAST_IDX = blk_idx_t'(NUM_BLOCKS - 1);

    // Remainder of x^(10+i) modulo the generator x^10+x^8+x^7+x^5+x^4+x^3+1,
    // one column of the parity matrix per information bit i.
    localparam check_t CHECK_COLS [INFO_W] = '{
        10'h1B9, 10'h372, 10'h35D, 10'h303,
        10'h3BF, 10'h2C7, 10'h037, 10'h06E,
        10'h0DC, 10'h1B8, 10'h370, 10'h359,
        10'h30B, 10'h3AF, 10'h2E7, 10'h077
    };

    // One group waiting for the back end: words and the offsets resolved for it.
    typedef struct packed {
        info_t  [NUM_BLOCKS-1:0] info;
        check_t [NUM_BLOCKS-1:0] offs;
    } group_entry_t;

    // The checkword is linear in the information bits, so it is an XOR of columns.
    function automatic check_t checkword(input info_t info);
        check_t acc;
        acc = '0;
        for (int i = 0; i < INFO_W; i++) begin
            if (info[i])
            begin
                acc = acc ^ CHECK_COLS[i];
            end
        end
        return acc;
    endfunction

endpackage

>>> src/rgbe_front.sv
module rgbe_front
    import rgbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  check_t               cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  info_t                info_a,
    input  info_t                info_b,
    input  info_t                info_c,
    input  info_t                info_d,
    input  logic                 version_b,
    input  logic                 q_full,
    output logic                 q_push,
    output group_entry_t         q_entry
);

    check_t offset_a_reg, offset_a_next;
    check_t offset_b_reg, offset_b_next;
    check_t offset_c_reg, offset_c_next;
    check_t offset_cp_reg, offset_cp_next;
    check_t offset_d_reg, offset_d_next;

    // Writes to an index with no register behind it are dropped.
    always_comb
    begin
        offset_a_next  = offset_a_reg;
        offset_b_next  = offset_b_reg;
        offset_c_next  = offset_c_reg;
        offset_cp_next = offset_cp_reg;
        offset_d_next  = offset_d_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_OFFSET_A:       offset_a_next  = cfg_data;
                REG_OFFSET_B:       offset_b_next  = cfg_data;
                REG_OFFSET_C:       offset_c_next  = cfg_data;
                REG_OFFSET_C_PRIME: offset_cp_next = cfg_data;
                REG_OFFSET_D:       offset_d_next  = cfg_data;
                default:            offset_a_next  = offset_a_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_a_reg  <= OFFSET_A_RST;
            offset_b_reg  <= OFFSET_B_RST;
            offset_c_reg  <= OFFSET_C_RST;
            offset_cp_reg <= OFFSET_C_PRIME_RST;
            offset_d_reg  <= OFFSET_D_RST;
        end
        else
        begin
            offset_a_reg  <= offset_a_next;
            offset_b_reg  <= offset_b_next;
            offset_c_reg  <= offset_c_next;
            offset_cp_reg <= offset_cp_next;
            offset_d_reg  <= offset_d_next;
        end
    end

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        q_entry.info[0] = info_a;
        q_entry.info[1] = info_b;
        q_entry.info[2] = info_c;
        q_entry.info[3] = info_d;
        q_entry.offs[0] = offset_a_reg;
        q_entry.offs[1] = offset_b_reg;
        q_entry.offs[2] = version_b ? offset_cp_reg : offset_c_reg;
        q_entry.offs[3] = offset_d_reg;
    end

endmodule

>>> src/rgbe_queue.sv
module rgbe_queue
    import rgbe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  group_entry_t push_entry,
    output logic         full,
    input  logic         pop,
    output logic         head_valid,
    output group_entry_t head_entry
);

    group_entry_t              slots [QUEUE_DEPTH];
    logic [QPTR_W-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0]         count_reg, count_next;
    logic                      do_push;
    logic                      do_pop;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        logic [QPTR_W-1:0] r;
        if (p == QPTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + 1'b1;
        end
        return r;
    endfunction

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_entry = slots[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = do_pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

>>> src/rgbe_back.sv
module rgbe_back
    import rgbe_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         head_valid,
    input  group_entry_t head_entry,
    output logic         pop,
    output logic         out_valid,
    input  logic         out_stall,
    output block_t       block_word,
    output blk_idx_t     block_index,
    output logic         last
);

    blk_idx_t cnt_reg, cnt_next;
    logic     out_valid_reg, out_valid_next;
    block_t   word_reg, word_next;
    blk_idx_t index_reg, index_next;
    logic     last_reg, last_next;
    logic     load;
    info_t    cur_info;
    check_t   cur_off;

    // A new word enters the output register whenever it is empty or being taken.
    assign load     = head_valid && (!out_valid_reg || !out_stall);
    assign pop      = load && (cnt_reg == LAST_IDX);
    assign cur_info = head_entry.info[cnt_reg];
    assign cur_off  = head_entry.offs[cnt_reg];

    always_comb
    begin
        cnt_next       = load ? cnt_reg + 1'b1 : cnt_reg;
        out_valid_next = out_valid_reg;
        word_next      = word_reg;
        index_next     = index_reg;
        last_next      = last_reg;
        if (load)
        begin
            out_valid_next = 1'b1;
            word_next      = {cur_info, checkword(cur_info) ^ cur_off};
            index_next     = cnt_reg;
            last_next      = (cnt_reg == LAST_IDX);
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg  <= word_next;
        index_reg <= index_next;
        last_reg  <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign block_word  = word_reg;
    assign block_index = index_reg;
    assign last        = last_reg;

endmodule

>>> src/rds_group_block_encoder.sv
// The first block of a group reaches the output through the queue and then the back end's output register.
// Throughput: one 26-bit block per cycle while out_stall is low and a group is
// queued; the back end's single checkword unit and output register set that rate.
// The two-entry queue lets the front take one further group while the back end works a group.
// Reset (rst_n, asynchronous, active low) empties the queue and output register
// and loads the offset registers with the standard offsets A, B, C, C' and D.
module rds_group_block_encoder
    import rgbe_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CHECK_W-1:0]   cfg_data,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [INFO_W-1:0]    info_a,
    input  logic [INFO_W-1:0]    info_b,
    input  logic [INFO_W-1:0]    info_c,
    input  logic [INFO_W-1:0]    info_d,
    input  logic                 version_b,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [BLOCK_W-1:0]   block_word,
    output logic [IDX_W-1:0]     block_index,
    output logic                 last
);

    // The front end holds the offset registers. For each accepted group it
    // resolves the four offsets of the group (choosing C or C' on the version
    // flag) and pushes words and offsets into the queue as one entry.
    logic         q_push;
    logic         q_full;
    group_entry_t q_entry;

    // The back end walks the head entry one block per cycle while not stalled,
    // computes the checkword with a parallel XOR network, adds the offset, and
    // registers the finished block. The entry is popped when its fourth block is loaded.
    logic         q_pop;
    logic         q_head_valid;
    group_entry_t q_head;

    rgbe_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .info_a    (info_a),
        .info_b    (info_b),
        .info_c    (info_c),
        .info_d    (info_d),
        .version_b (version_b),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    // The queue decouples the two sides: input stall follows only its fill
    // level, and output stall only holds the back end's output register.
    rgbe_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head)
    );

    rgbe_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head_valid  (q_head_valid),
        .head_entry  (q_head),
        .pop         (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .block_word  (block_word),
        .block_index (block_index),
        .last        (last)
    );

endmodule

>>> src/rgbe_checker.sv
module rgbe_checker
    import rgbe_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [BLOCK_W-1:0] block_word,
    input logic [IDX_W-1:0]   block_index,
    input logic               last
);

    logic       in_acc;
    logic       out_acc;
    blk_idx_t   exp_idx_reg, exp_idx_next;
    logic [3:0] pending_reg, pending_next;

    assign in_acc  = in_valid && !in_stall;
    assign out_acc = out_valid && !out_stall;

    // Expected position of the next word, and groups accepted but not finished.
    always_comb
    begin
        exp_idx_next = out_acc ? exp_idx_reg + 1'b1 : exp_idx_reg;
        pending_next = pending_reg;
        if (in_acc && !(out_acc && last))
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!in_acc && out_acc && last)
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            exp_idx_reg <= '0;
            pending_reg <= '0;
        end
        else
        begin
            exp_idx_reg <= exp_idx_next;
            pending_reg <= pending_next;
        end
    end

    a_last_on_fourth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last == (block_index == LAST_IDX)))
        else $error("last flag does not match block position");

    a_index_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (block_index == exp_idx_reg))
        else $error("block position out of order");

    a_no_invented_group: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (pending_reg != '0))
        else $error("word shown with no group outstanding");

    a_stalled_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=>
            (out_valid && $stable(block_word) && $stable(block_index)))
        else $error("stalled output word changed");

endmodule

bind rds_group_block_encoder rgbe_checker u_rgbe_checker (.*);
